@@ rtl/sprite_nibble_palette_line_assert.svh @@
// Assertion macros for the sprite line decoder checker.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef SPRITE_NIBBLE_PALETTE_LINE_ASSERT_SVH
`define SPRITE_NIBBLE_PALETTE_LINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SNPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SNPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/snpl_pkg.sv @@
// Shared types, constants and helper functions of the sprite line decoder.
// No dependencies.
package snpl_pkg;

  localparam int unsigned LINE_WIDTH_DEF  = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned X_W        = 13;
  localparam int unsigned XS_W       = 14;
  localparam int unsigned START_X_W  = 11;
  localparam int unsigned PIX_X_W    = 10;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned RUN_W      = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PAL_W      = 4 * CFG_DATA_W;

  // Highest position; reaching it counts as beyond the line.
  localparam logic signed [XS_W-1:0] X_SAT = 14'sd4095;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X   = 3'd0,
    REG_PAL_0_3   = 3'd1,
    REG_PAL_4_7   = 3'd2,
    REG_PAL_8_11  = 3'd3,
    REG_PAL_12_15 = 3'd4
  } cfg_reg_t;

  // One classified word passed from the front end to the back end.
  typedef struct packed {
    logic signed [X_W-1:0] x0;        // position of the first pixel
    logic [CNT_W-1:0]      cnt;       // pixels in this word, 0 to 8
    logic [WORD_W-1:0]     nibbles;   // pixel indices, lowest nibble first
    logic                  done_line; // word completes the end-of-line run
  } word_t;

  // Upper saturation of a position; sums here only ever grow.
  function automatic logic signed [X_W-1:0] sat_x(input logic signed [XS_W-1:0] v);
    logic signed [X_W-1:0] r;
    r = (v > X_SAT) ? X_SAT[X_W-1:0] : v[X_W-1:0];
    return r;
  endfunction

  // Palette lookup: entry k sits at bits 16k upward of the packed palette.
  function automatic logic [COLOR_W-1:0] pal_lookup(input logic [PAL_W-1:0] pal,
                                                    input logic [3:0] idx);
    logic [COLOR_W-1:0] c;
    c = pal[{idx, 4'b0000} +: COLOR_W];
    return c;
  endfunction

endpackage

@@ rtl/snpl_front.sv @@
// Front end of the sprite line decoder: parses header and data words,
// tracks the run state and position, and pushes one classified word per item.
// Depends on snpl_pkg.
module snpl_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [snpl_pkg::START_X_W-1:0] start_x,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [snpl_pkg::WORD_W-1:0]         in_stream_word,
  input  logic                                q_full,
  output logic                                q_push,
  output snpl_pkg::word_t                     q_data
);

  logic signed [snpl_pkg::X_W-1:0]  cur_x_r, cur_x_nxt;
  logic [snpl_pkg::RUN_W-1:0]       pixels_left_r, pixels_left_nxt;
  logic                             expect_header_r, expect_header_nxt;
  logic                             at_line_start_r, at_line_start_nxt;
  logic                             run_is_eol_r, run_is_eol_nxt;

  logic                             eol;
  logic [snpl_pkg::RUN_W-1:0]       run_len;
  logic [snpl_pkg::RUN_W-1:0]       skip;
  logic [snpl_pkg::CNT_W-1:0]       cnt;
  logic [snpl_pkg::RUN_W-1:0]       rem;
  logic signed [snpl_pkg::X_W-1:0]  base;
  logic signed [snpl_pkg::XS_W-1:0] base_sum;
  logic signed [snpl_pkg::XS_W-1:0] end_sum;
  logic signed [snpl_pkg::X_W-1:0]  x0;
  logic                             done_line;
  logic                             accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept;

  // Header fields.
  assign eol     = in_stream_word[0];
  assign run_len = in_stream_word[7:1];
  assign skip    = in_stream_word[15:9];

  // Classify the word: pixel count, first position, remaining run.
  always_comb begin
    if (expect_header_r) begin
      cnt = (run_len < 7'd4) ? run_len[snpl_pkg::CNT_W-1:0] : 4'd4;
    end else begin
      cnt = (pixels_left_r < 7'd8) ? pixels_left_r[snpl_pkg::CNT_W-1:0] : 4'd8;
    end
    rem = (expect_header_r ? run_len : pixels_left_r) - {3'b000, cnt};

    base     = at_line_start_r ? {{2{start_x[snpl_pkg::START_X_W-1]}}, start_x} : cur_x_r;
    base_sum = {base[snpl_pkg::X_W-1], base} + {7'b0000000, skip};
    x0       = expect_header_r ? snpl_pkg::sat_x(base_sum) : cur_x_r;
    end_sum  = {x0[snpl_pkg::X_W-1], x0} + {10'b0000000000, cnt};

    if (expect_header_r) begin
      done_line = (rem == '0) && eol;
    end else begin
      done_line = (rem == '0) && run_is_eol_r;
    end
  end

  // Next run state.
  always_comb begin
    cur_x_nxt         = cur_x_r;
    pixels_left_nxt   = pixels_left_r;
    expect_header_nxt = expect_header_r;
    at_line_start_nxt = at_line_start_r;
    run_is_eol_nxt    = run_is_eol_r;
    if (accept) begin
      cur_x_nxt         = snpl_pkg::sat_x(end_sum);
      pixels_left_nxt   = rem;
      expect_header_nxt = (rem == '0);
      if (expect_header_r) begin
        if (rem != '0) begin
          run_is_eol_nxt = eol;
        end
      end else if (rem == '0) begin
        run_is_eol_nxt = 1'b0;
      end
      if (done_line) begin
        at_line_start_nxt = 1'b1;
      end else if (expect_header_r) begin
        at_line_start_nxt = 1'b0;
      end
    end
  end

  // Classified word for the queue.
  always_comb begin
    q_data.x0        = x0;
    q_data.cnt       = cnt;
    q_data.nibbles   = expect_header_r ? {16'h0000, in_stream_word[31:16]} : in_stream_word;
    q_data.done_line = done_line;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r         <= '0;
      pixels_left_r   <= '0;
      expect_header_r <= 1'b1;
      at_line_start_r <= 1'b1;
      run_is_eol_r    <= 1'b0;
    end else begin
      cur_x_r         <= cur_x_nxt;
      pixels_left_r   <= pixels_left_nxt;
      expect_header_r <= expect_header_nxt;
      at_line_start_r <= at_line_start_nxt;
      run_is_eol_r    <= run_is_eol_nxt;
    end
  end

endmodule

@@ rtl/snpl_queue.sv @@
// Short queue of classified words between the front and back ends.
// Depends on snpl_pkg.
module snpl_queue #(
  parameter int unsigned DEPTH = snpl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  snpl_pkg::word_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output snpl_pkg::word_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  snpl_pkg::word_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill count update, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/snpl_back.sv @@
// Back end of the sprite line decoder: steps through the head word's pixels
// one per cycle into the output register while it is free or being taken.
// Depends on snpl_pkg.
module snpl_back #(
  parameter int unsigned LINE_WIDTH = snpl_pkg::LINE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [snpl_pkg::PAL_W-1:0]       palette,
  input  logic                             q_empty,
  input  snpl_pkg::word_t                  q_head,
  output logic                             q_pop,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [snpl_pkg::PIX_X_W-1:0]     out_pixel_x,
  output logic [snpl_pkg::COLOR_W-1:0]     out_color,
  output logic                             out_write_enable,
  output logic                             out_last,
  output logic                             out_line_end
);

  localparam logic signed [snpl_pkg::XS_W-1:0] LW = snpl_pkg::XS_W'(LINE_WIDTH);

  logic [2:0]                       k_r, k_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [snpl_pkg::PIX_X_W-1:0]     pixel_x_r;
  logic [snpl_pkg::COLOR_W-1:0]     color_r;
  logic                             we_r, last_r, line_end_r;

  logic                             adv;
  logic signed [snpl_pkg::XS_W-1:0] xs;
  logic                             in_line;
  logic                             last;
  logic [3:0]                       nib;

  assign out_empty        = !out_valid_r;
  assign out_pixel_x      = pixel_x_r;
  assign out_color        = color_r;
  assign out_write_enable = we_r;
  assign out_last         = last_r;
  assign out_line_end     = line_end_r;

  // A result moves into the output register when it is free or being taken.
  assign adv   = !q_empty && (!out_valid_r || out_pop);
  assign q_pop = adv && last;

  // Current pixel of the head word.
  always_comb begin
    xs      = {q_head.x0[snpl_pkg::X_W-1], q_head.x0} + {11'b00000000000, k_r};
    in_line = (q_head.cnt != '0) && (xs >= 0) && (xs < LW) && (xs < snpl_pkg::X_SAT);
    last    = (q_head.cnt == '0) || ({1'b0, k_r} == q_head.cnt - 1'b1);
    nib     = q_head.nibbles[{k_r, 2'b00} +: 4];
  end

  // Pixel counter and output valid.
  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      k_nxt         = last ? 3'd0 : k_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; writes outside the line carry zero position and colour.
  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_x_r  <= in_line ? xs[snpl_pkg::PIX_X_W-1:0] : '0;
      color_r    <= in_line ? snpl_pkg::pal_lookup(palette, nib) : '0;
      we_r       <= in_line;
      last_r     <= last;
      line_end_r <= q_head.done_line;
    end
  end

endmodule

@@ rtl/sprite_nibble_palette_line.sv @@
// Top level of the 4-bit palettized sprite line decoder.
// Holds the configuration registers; depends on snpl_pkg, snpl_front,
// snpl_queue and snpl_back.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_push / in_full   in_stream_word
//   out_     output     out_empty / out_pop out_pixel_x, out_color,
//                                           out_write_enable, out_last,
//                                           out_line_end
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// The front end takes one word per cycle while the queue has room.
// The back end gives one result per cycle while its output is free or being
// taken; a word gives max(1, pixels in the word) results: one to eight.
// The first result of an item reaches the output register after the item is written into the queue.
// Reset is synchronous and active low; it empties the queue and output register.
// A stalled output holds its result; the queue then fills and raises in_full.
module sprite_nibble_palette_line #(
  parameter int unsigned LINE_WIDTH  = snpl_pkg::LINE_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = snpl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [snpl_pkg::WORD_W-1:0]        in_stream_word,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [snpl_pkg::PIX_X_W-1:0]       out_pixel_x,
  output logic [snpl_pkg::COLOR_W-1:0]       out_color,
  output logic                               out_write_enable,
  output logic                               out_last,
  output logic                               out_line_end,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [snpl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [snpl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic signed [snpl_pkg::START_X_W-1:0] start_x_r;
  logic [snpl_pkg::CFG_DATA_W-1:0]       pal_0_3_r, pal_4_7_r, pal_8_11_r, pal_12_15_r;

  logic            q_push, q_full, q_pop, q_empty;
  snpl_pkg::word_t q_wdata, q_head;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= '0;
      pal_0_3_r   <= '0;
      pal_4_7_r   <= '0;
      pal_8_11_r  <= '0;
      pal_12_15_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        snpl_pkg::REG_START_X:   start_x_r   <= cfg_data[snpl_pkg::START_X_W-1:0];
        snpl_pkg::REG_PAL_0_3:   pal_0_3_r   <= cfg_data;
        snpl_pkg::REG_PAL_4_7:   pal_4_7_r   <= cfg_data;
        snpl_pkg::REG_PAL_8_11:  pal_8_11_r  <= cfg_data;
        snpl_pkg::REG_PAL_12_15: pal_12_15_r <= cfg_data;
        default: ;
      endcase
    end
  end

  snpl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start_x        (start_x_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_stream_word (in_stream_word),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  snpl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  snpl_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .palette          ({pal_12_15_r, pal_8_11_r, pal_4_7_r, pal_0_3_r}),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_x      (out_pixel_x),
    .out_color        (out_color),
    .out_write_enable (out_write_enable),
    .out_last         (out_last),
    .out_line_end     (out_line_end)
  );

endmodule

@@ rtl/snpl_checker.sv @@
// Port-level checker for the sprite line decoder, bound to the top level.
// Depends on snpl_pkg and sprite_nibble_palette_line_assert.svh.
`include "sprite_nibble_palette_line_assert.svh"

module snpl_checker #(
  parameter int unsigned LINE_WIDTH = snpl_pkg::LINE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic [snpl_pkg::PIX_X_W-1:0]   out_pixel_x,
  input logic [snpl_pkg::COLOR_W-1:0]   out_color,
  input logic                           out_write_enable,
  input logic                           out_last,
  input logic                           out_line_end
);

  // Real writes land inside the line.
  `SNPL_ASSERT_NOW(a_write_in_line, !out_empty && out_write_enable, 32'(out_pixel_x) < LINE_WIDTH, "pixel write beyond the line")

  // Dropped writes carry zero position and colour.
  `SNPL_ASSERT_NOW(a_dropped_zero, !out_empty && !out_write_enable, out_pixel_x == '0 && out_color == '0, "dropped write with non-zero payload")

  // A waiting result is not withdrawn.
  `SNPL_ASSERT_NEXT(a_result_held, !out_empty && !out_pop, !out_empty, "result withdrawn before it was taken")

  // Every result of a line-ending word carries line_end.
  `SNPL_ASSERT_NEXT(a_line_end_word, !out_empty && out_pop && out_line_end && !out_last, out_empty || out_line_end, "line_end dropped within one word")

endmodule

bind sprite_nibble_palette_line snpl_checker #(.LINE_WIDTH(LINE_WIDTH)) u_snpl_checker (.*);

@@ verif/snpl_line_checker.sv @@
// Checker for the sprite line decoder: watches the input, result and register channels,
// predicts the pixel writes of every accepted item and compares them with the block.
// Depends on snpl_pkg for widths and register indexes.
module snpl_line_checker
  import snpl_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [WORD_W-1:0]     in_stream_word,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic [PIX_X_W-1:0]    out_pixel_x,
  input  logic [COLOR_W-1:0]    out_color,
  input  logic                  out_write_enable,
  input  logic                  out_last,
  input  logic                  out_line_end,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count,
  output int                    results_checked,
  output int                    pixel_writes,
  output int                    lines_done
);
  timeunit 1ns;
  timeprecision 1ps;

  // Bounds of the position counter; the top value counts as beyond the line.
  localparam int X_TOP    = 4095;
  localparam int X_BOTTOM = -4096;

  typedef struct packed {
    logic [PIX_X_W-1:0] pixel_x;
    logic [COLOR_W-1:0] color;
    logic               write_enable;
    logic               last;
    logic               line_end;
  } pixel_write_t;

  // Writes still owed by the block, oldest first.
  pixel_write_t pending_writes[$];

  // Decoder state as the block should hold it.
  int  line_x;
  int  run_left;
  bit  want_header;
  bit  line_fresh;
  bit  run_ends_line;

  // Register copies, updated from the register channel.
  logic signed [START_X_W-1:0] start_x_reg;
  logic [CFG_DATA_W-1:0]       palette_reg [4];

  function automatic int clamp_pos(input int v);
    if (v > X_TOP) return X_TOP;
    if (v < X_BOTTOM) return X_BOTTOM;
    return v;
  endfunction

  // One pixel at the current position; the position moves on whether or not it is written.
  function automatic pixel_write_t paint_pixel(input logic [3:0] idx);
    pixel_write_t pw;
    pw = '0;
    if (line_x >= 0 && line_x < int'(LINE_WIDTH) && line_x < X_TOP) begin
      pw.pixel_x      = line_x[PIX_X_W-1:0];
      pw.color        = palette_reg[idx[3:2]][{idx[1:0], 4'b0000} +: COLOR_W];
      pw.write_enable = 1'b1;
    end
    line_x = clamp_pos(line_x + 1);
    return pw;
  endfunction

  // Works out the results of one stream word and queues them.
  task automatic decode_word(input logic [WORD_W-1:0] w);
    pixel_write_t batch[$];
    int           run_len;
    int           n_pix;
    bit           ends_line;
    batch     = {};
    ends_line = 1'b0;
    if (want_header) begin
      run_len = w[7:1];
      if (line_fresh) begin
        line_x     = start_x_reg;
        line_fresh = 1'b0;
      end
      line_x = clamp_pos(line_x + int'(w[15:9]));
      n_pix  = (run_len < 4) ? run_len : 4;
      for (int i = 0; i < n_pix; i++) batch.push_back(paint_pixel(w[16 + 4 * i +: 4]));
      run_left = run_len - n_pix;
      if (run_left != 0) begin
        want_header   = 1'b0;
        run_ends_line = w[0];
      end else if (w[0]) begin
        ends_line = 1'b1;
      end
    end else begin
      n_pix = (run_left < 8) ? run_left : 8;
      for (int i = 0; i < n_pix; i++) batch.push_back(paint_pixel(w[4 * i +: 4]));
      run_left -= n_pix;
      if (run_left == 0) begin
        want_header   = 1'b1;
        ends_line     = run_ends_line;
        run_ends_line = 1'b0;
      end
    end
    if (ends_line) line_fresh = 1'b1;
    // A word without pixels still gives one empty result.
    if (batch.size() == 0) batch.push_back('0);
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) begin
      batch[k].line_end = ends_line;
      pending_writes.push_back(batch[k]);
    end
  endtask

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endfunction

  // Results are compared before the same edge's item is predicted.
  always @(posedge clk) begin
    pixel_write_t want;
    if (!rst_n) begin
      line_x          = 0;
      run_left        = 0;
      want_header     = 1'b1;
      line_fresh      = 1'b1;
      run_ends_line   = 1'b0;
      start_x_reg     = '0;
      palette_reg     = '{default: '0};
      pending_writes.delete();
      fail_count      = 0;
      results_checked = 0;
      pixel_writes    = 0;
      lines_done      = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_writes.size() == 0) begin
          $error("result with no item outstanding: pixel_x 0x%0h color 0x%0h",
                 out_pixel_x, out_color);
          fail_count++;
        end else begin
          want = pending_writes.pop_front();
          check_field("pixel_x", 16'(want.pixel_x), 16'(out_pixel_x));
          check_field("color", want.color, out_color);
          check_field("write_enable", 16'(want.write_enable), 16'(out_write_enable));
          check_field("last", 16'(want.last), 16'(out_last));
          check_field("line_end", 16'(want.line_end), 16'(out_line_end));
          results_checked++;
          if (want.write_enable) pixel_writes++;
          if (want.line_end && want.last) lines_done++;
        end
      end
      if (in_push && !in_full) decode_word(in_stream_word);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_START_X) begin
          start_x_reg = cfg_data[START_X_W-1:0];
        end else if (cfg_index <= REG_PAL_12_15) begin
          palette_reg[cfg_index - REG_PAL_0_3] = cfg_data;
        end
      end
    end
    pending_count = pending_writes.size();
  end

endmodule

@@ verif/sprite_nibble_palette_line_test.sv @@
// Top of the sprite line decoder test: drives sprite line streams and register writes,
// stalls both sides at random and gives the verdict.
// Depends on snpl_pkg, sprite_nibble_palette_line and snpl_line_checker.
module sprite_nibble_palette_line_test;
  timeunit 1ns;
  timeprecision 1ps;
  import snpl_pkg::*;

  localparam int MAX_PAUSE       = 18;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TARGET_ITEMS    = 200;
  localparam int TX              = 0;
  localparam int RX              = 1;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_push          = 1'b0;
  logic                  in_full;
  logic [WORD_W-1:0]     in_stream_word   = '0;
  logic                  out_empty;
  logic                  out_pop          = 1'b0;
  logic [PIX_X_W-1:0]    out_pixel_x;
  logic [COLOR_W-1:0]    out_color;
  logic                  out_write_enable;
  logic                  out_last;
  logic                  out_line_end;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = REG_START_X;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  int fail_count;
  int pending_count;
  int results_checked;
  int pixel_writes;
  int lines_done;

  int words_sent   = 0;
  int quiet_cycles = 0;
  int burst_left [2] = '{0, 0};
  bit fill_req     = 1'b0;
  bit held_off     = 1'b0;

  sprite_nibble_palette_line i_dut (.*);

  snpl_line_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pause before the next item: random, but with bursts of back-to-back items.
  function automatic int draw_pause(input int side);
    if (burst_left[side] > 0) begin
      burst_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left[side] = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, MAX_PAUSE);
  endfunction

  function automatic logic [PAL_W-1:0] rand_palette();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Offers one word from a falling edge and returns at the falling edge after acceptance.
  task automatic send_word(input logic [WORD_W-1:0] w);
    int gap;
    gap = fill_req ? 0 : draw_pause(TX);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push        <= 1'b1;
    in_stream_word <= w;
    do @(posedge clk); while (in_full);
    words_sent++;
    @(negedge clk);
  endtask

  // A header with random pixel indices and spare bit, then its data words.
  task automatic send_run(input bit eol, input int len, input int skip);
    logic [WORD_W-1:0] head;
    head       = $urandom;
    head[0]    = eol;
    head[7:1]  = len[6:0];
    head[15:9] = skip[6:0];
    send_word(head);
    for (int k = 4; k < len; k += 8) send_word($urandom);
  endtask

  // Mostly well-formed lines of short runs, with a few long runs and stray words.
  task automatic run_phase(input int n_items);
    int goal;
    int runs;
    goal = words_sent + n_items;
    while (words_sent < goal) begin
      if ($urandom_range(0, 7) == 0) begin
        send_word($urandom);
      end else begin
        runs = $urandom_range(1, 4);
        for (int r = 1; r <= runs; r++) begin
          send_run(r == runs && $urandom_range(0, 5) != 0,
                   ($urandom_range(0, 11) == 0) ? $urandom_range(21, 127)
                                                : $urandom_range(0, 20),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(0, 24));
        end
      end
    end
  endtask

  // Stops offering items and waits until every expected result has been taken.
  task automatic settle();
    in_push <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic write_config(input logic signed [START_X_W-1:0] sx,
                              input logic [PAL_W-1:0] pal);
    settle();
    write_reg(REG_START_X, 64'(sx));
    write_reg(REG_PAL_0_3, pal[0 +: CFG_DATA_W]);
    write_reg(REG_PAL_4_7, pal[CFG_DATA_W +: CFG_DATA_W]);
    write_reg(REG_PAL_8_11, pal[2 * CFG_DATA_W +: CFG_DATA_W]);
    write_reg(REG_PAL_12_15, pal[3 * CFG_DATA_W +: CFG_DATA_W]);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty headers, exact and short runs, the longest run with a partial word.
    write_config(11'sd0, rand_palette());
    send_word({16'h0000, 7'd0, 1'b0, 7'd0, 1'b0});
    send_word({16'hFFFF, 7'd127, 1'b1, 7'd0, 1'b1});
    send_word({16'h3210, 7'd0, 1'b0, 7'd4, 1'b0});
    send_word({16'hFEDC, 7'd2, 1'b0, 7'd3, 1'b1});
    send_run(1'b1, 127, 127);

    // Directed: writes left of the line, then straddling its right end.
    write_config(-11'sd1024, '1);
    send_run(1'b1, 4, 0);
    write_config(11'sd1023, '0);
    send_run(1'b0, 4, 0);
    send_run(1'b1, 12, 0);

    // Wide skips from the right end until the position saturates.
    write_config(11'sd1023, rand_palette());
    for (int h = 0; h < 28; h++) begin
      send_word({16'($urandom), 7'($urandom_range(120, 127)), 1'($urandom),
                 7'($urandom_range(1, 4)), 1'b0});
    end
    send_run(1'b1, 8, 0);

    // Back-to-back items while the receiver holds off.
    write_config(START_X_W'($urandom), rand_palette());
    fill_req = 1'b1;
    run_phase(40);
    fill_req = 1'b0;

    write_config(-11'sd1024, '1);
    run_phase(35);

    write_config(START_X_W'($urandom_range(0, 255)), rand_palette());
    run_phase(TARGET_ITEMS - words_sent);

    settle();
    $display("Sent %0d stream words; checked %0d results, %0d of them pixel writes, %0d lines.",
             words_sent, results_checked, pixel_writes, lines_done);
    $display("Receiver held off for %0d cycles once with the input backed up.",
             HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random pauses, and one long hold-off once the sender floods the input.
  initial begin
    int pause;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (fill_req && !held_off) begin
        held_off = 1'b1;
        pause    = HOLD_OFF_CYCLES;
      end else begin
        pause = draw_pause(RX);
      end
      if (pause > 0) begin
        out_pop <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/snpl_pkg.sv
rtl/snpl_front.sv
rtl/snpl_queue.sv
rtl/snpl_back.sv
rtl/sprite_nibble_palette_line.sv
rtl/snpl_checker.sv
verif/snpl_line_checker.sv
verif/sprite_nibble_palette_line_test.sv
